FILE: src/bucketed_hash_set_assert.svh
// ----------------------------------------------------------------------------
// bucketed_hash_set assertion macros
// concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef BUCKETED_HASH_SET_ASSERT_SVH
`define BUCKETED_HASH_SET_ASSERT_SVH

`ifndef SYNTHESIS
`define BHS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bucketed_hash_set assertion failed");
`define BHS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("bucketed_hash_set assertion failed");
`else
`define BHS_ASSERT(name, clk, rst_n, prop)
`define BHS_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

FILE: src/bhs_pkg.sv
// ----------------------------------------------------------------------------
// bhs_pkg
// shared codes and state types of the bucketed hash set
// ----------------------------------------------------------------------------
package bhs_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] CFG_SLOTS = 2'd0;
  localparam logic [1:0] CFG_WAYS  = 2'd1;

  localparam logic [31:0] HASH_SEED  = 32'd5381;
  localparam int          HASH_SHIFT = 5;

  typedef enum logic [1:0] {
    H_IDLE,
    H_BYTE,
    H_DIV,
    H_DONE
  } bhs_hash_state_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_ROW,
    S_COUNT,
    S_RD,
    S_CMP,
    S_SH_RD,
    S_SH_WR,
    S_CLRV,
    S_DONE
  } bhs_state_e;

endpackage

FILE: src/bhs_ram.sv
// ----------------------------------------------------------------------------
// bhs_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bhs_hash.sv
// ----------------------------------------------------------------------------
// bhs_hash
// djb2 over the key one byte a cycle, then restoring modulo one bit a cycle
// ----------------------------------------------------------------------------
module bhs_hash import bhs_pkg::*; #(
  parameter int DIV_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [63:0]      key_i,
  input  logic [3:0]       len_i,
  input  logic [DIV_W-1:0] div_i,
  output logic             done_o,
  output logic [DIV_W-1:0] rem_o
);

  bhs_hash_state_e state_q, state_d;
  logic [31:0]      h_q, h_d;
  logic [63:0]      key_q, key_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W:0]   trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    key_q <= key_d;
    rem_q <= rem_d;
  end

  assign trial = {rem_q, h_q[31]};

  always_comb begin
    state_d = state_q;
    h_d     = h_q;
    key_d   = key_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    case (state_q)
      H_IDLE: begin
        if (start_i) begin
          h_d     = HASH_SEED;
          key_d   = key_i;
          cnt_d   = {2'b00, len_i};
          state_d = H_BYTE;
        end
      end
      H_BYTE: begin
        if (cnt_q == '0) begin
          rem_d   = '0;
          cnt_d   = 6'd32;
          state_d = H_DIV;
        end else begin
          h_d   = (h_q << HASH_SHIFT) + h_q + {24'b0, key_q[7:0]};
          key_d = key_q >> 8;
          cnt_d = cnt_q - 6'd1;
        end
      end
      H_DIV: begin
        // remainder stays below the divisor, so the trial fits one extra bit
        if (trial >= {1'b0, div_i}) begin
          rem_d = DIV_W'(trial - {1'b0, div_i});
        end else begin
          rem_d = trial[DIV_W-1:0];
        end
        h_d   = h_q << 1;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          state_d = H_DONE;
        end
      end
      H_DONE: begin
        state_d = H_IDLE;
      end
      default: begin
        state_d = H_IDLE;
      end
    endcase
  end

  assign done_o = (state_q == H_DONE);
  assign rem_o  = rem_q;

endmodule

FILE: src/bucketed_hash_set.sv
// ----------------------------------------------------------------------------
// bucketed_hash_set
// hash set of 0..8 byte keys in djb2 buckets of packed ways
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    mode, key, key_len
// out      output     out_valid/out_stall  status, slot, way
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// from the input beat to the result register: the key is hashed and reduced
// modulo the slot count and the bucket row is read; a lookup or remove compares
// the used ways in turn, and a remove hit shifts the later ways down and clears
// the last valid bit; the next input beat is taken in the cycle after the result
// register is loaded; byte-serial hash, 32-step modulo and one key ram port set
// the pace; after reset the valid ram is swept one bucket a cycle over all SLOTS
// buckets with in_stall high, cfg writes taken meanwhile; one item is in work at
// a time; a result waiting on out_stall does not block the next input beat
// ----------------------------------------------------------------------------
module bucketed_hash_set import bhs_pkg::*; #(
  parameter int SLOTS     = 256,
  parameter int WAYS      = 4,
  parameter int KEY_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [63:0] key_i,
  input  logic [3:0]  key_len_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  slot_o,
  output logic [1:0]  way_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  `include "bucketed_hash_set_assert.svh"

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int DIV_W  = $clog2(SLOTS + 1);
  localparam int WCNT_W = $clog2(WAYS + 1);
  localparam int KAW    = SLOT_W + WAY_W;
  localparam int KDEPTH = SLOTS << WAY_W;

  bhs_state_e state_q, state_d;

  logic [8:0]        slots_q;
  logic [2:0]        ways_q;
  logic [DIV_W-1:0]  eff_slots;
  logic [WCNT_W-1:0] eff_ways;

  logic [1:0]        mode_q, mode_d;
  logic [63:0]       key_q, key_d;
  logic [3:0]        len_q, len_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [WAYS-1:0]   row_q, row_d;
  logic [WCNT_W-1:0] count_q, count_d;
  logic [WCNT_W-1:0] w_q, w_d;
  logic [WCNT_W-1:0] j_q, j_d;
  logic [SLOT_W-1:0] clr_q, clr_d;
  logic [1:0]        res_status_q, res_status_d;
  logic [WCNT_W-1:0] res_way_q, res_way_d;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        status_q, status_d;
  logic [7:0]        slot_out_q, slot_out_d;
  logic [1:0]        way_q, way_d;

  logic [3:0]        len_c;
  logic [63:0]       key_c;
  logic              hash_start, hash_done;
  logic [DIV_W-1:0]  hash_rem;

  logic              k_we, k_re;
  logic [KAW-1:0]    k_waddr, k_raddr;
  logic [67:0]       k_wdata, k_rdata;
  logic              v_we, v_re;
  logic [SLOT_W-1:0] v_waddr, v_raddr;
  logic [WAYS-1:0]   v_wdata, v_rdata;

  logic [WCNT_W-1:0] free_cnt;
  logic              match;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= 9'd256;
      ways_q  <= 3'd4;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SLOTS: slots_q <= cfg_data_i;
        CFG_WAYS:  ways_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (slots_q == 9'd0) begin
      eff_slots = DIV_W'(1);
    end else if ({23'b0, slots_q} > 32'(SLOTS)) begin
      eff_slots = DIV_W'(SLOTS);
    end else begin
      eff_slots = DIV_W'(slots_q);
    end
    if (ways_q == 3'd0) begin
      eff_ways = WCNT_W'(1);
    end else if ({29'b0, ways_q} > 32'(WAYS)) begin
      eff_ways = WCNT_W'(WAYS);
    end else begin
      eff_ways = WCNT_W'(ways_q);
    end
  end

  // clamp the length and zero the bytes past it
  always_comb begin
    len_c = (key_len_i > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_len_i;
    for (int i = 0; i < 8; i++) begin
      key_c[i*8 +: 8] = (4'(i) < len_c) ? key_i[i*8 +: 8] : 8'h00;
    end
  end

  bhs_hash #(
    .DIV_W (DIV_W)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (key_q),
    .len_i   (len_q),
    .div_i   (eff_slots),
    .done_o  (hash_done),
    .rem_o   (hash_rem)
  );

  // key and length per entry
  bhs_ram #(
    .WIDTH (68),
    .DEPTH (KDEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr),
    .wdata_i (k_wdata),
    .re_i    (k_re),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  // valid bits, one row per bucket
  bhs_ram #(
    .WIDTH (WAYS),
    .DEPTH (SLOTS)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .re_i    (v_re),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  // first free way among the used ways
  always_comb begin
    logic found;
    found    = 1'b0;
    free_cnt = eff_ways;
    for (int i = 0; i < WAYS; i++) begin
      if (!found && (WCNT_W'(i) < eff_ways) && !v_rdata[i]) begin
        found    = 1'b1;
        free_cnt = WCNT_W'(i);
      end
    end
  end

  assign match = (k_rdata[67:64] == len_q) && (k_rdata[63:0] == key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    len_q        <= len_d;
    slot_q       <= slot_d;
    row_q        <= row_d;
    count_q      <= count_d;
    w_q          <= w_d;
    j_q          <= j_d;
    res_status_q <= res_status_d;
    res_way_q    <= res_way_d;
    status_q     <= status_d;
    slot_out_q   <= slot_out_d;
    way_q        <= way_d;
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    mode_d       = mode_q;
    key_d        = key_q;
    len_d        = len_q;
    slot_d       = slot_q;
    row_d        = row_q;
    count_d      = count_q;
    w_d          = w_q;
    j_d          = j_q;
    res_status_d = res_status_q;
    res_way_d    = res_way_q;
    status_d     = status_q;
    slot_out_d   = slot_out_q;
    way_d        = way_q;
    out_valid_d  = out_valid_q && out_stall_i;

    in_stall_o = 1'b1;
    hash_start = 1'b0;
    k_we       = 1'b0;
    k_waddr    = {slot_q, count_q[WAY_W-1:0]};
    k_wdata    = {len_q, key_q};
    k_re       = 1'b0;
    k_raddr    = {slot_q, w_q[WAY_W-1:0]};
    v_we       = 1'b0;
    v_waddr    = slot_q;
    v_wdata    = row_q;
    v_re       = 1'b0;
    v_raddr    = slot_q;

    case (state_q)
      S_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = clr_q;
        v_wdata = '0;
        clr_d   = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          mode_d  = mode_i;
          key_d   = key_c;
          len_d   = len_c;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        hash_start = 1'b1;
        if (hash_done) begin
          slot_d  = SLOT_W'(hash_rem);
          state_d = S_ROW;
        end
      end
      S_ROW: begin
        v_re    = 1'b1;
        state_d = S_COUNT;
      end
      S_COUNT: begin
        row_d   = v_rdata;
        count_d = free_cnt;
        w_d     = '0;
        if (mode_q == MODE_INSERT) begin
          if (free_cnt < eff_ways) begin
            k_we         = 1'b1;
            k_waddr      = {slot_q, free_cnt[WAY_W-1:0]};
            v_we         = 1'b1;
            v_wdata      = v_rdata | (WAYS'(1) << free_cnt[WAY_W-1:0]);
            res_status_d = ST_DONE;
            res_way_d    = free_cnt;
          end else begin
            res_status_d = ST_FULL;
            res_way_d    = '0;
          end
          state_d = S_DONE;
        end else if (free_cnt == '0) begin
          res_status_d = ST_MISS;
          res_way_d    = '0;
          state_d      = S_DONE;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        k_re    = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (match) begin
          res_status_d = ST_DONE;
          res_way_d    = w_q;
          if (mode_q == MODE_REMOVE) begin
            j_d     = w_q + WCNT_W'(1);
            state_d = S_SH_RD;
          end else begin
            state_d = S_DONE;
          end
        end else if (w_q + WCNT_W'(1) == count_q) begin
          res_status_d = ST_MISS;
          res_way_d    = '0;
          state_d      = S_DONE;
        end else begin
          w_d     = w_q + WCNT_W'(1);
          state_d = S_RD;
        end
      end
      S_SH_RD: begin
        k_raddr = {slot_q, j_q[WAY_W-1:0]};
        if (j_q >= count_q) begin
          state_d = S_CLRV;
        end else begin
          k_re    = 1'b1;
          state_d = S_SH_WR;
        end
      end
      S_SH_WR: begin
        // move way j down to j-1
        k_we    = 1'b1;
        k_waddr = {slot_q, WAY_W'(j_q - WCNT_W'(1))};
        k_wdata = k_rdata;
        j_d     = j_q + WCNT_W'(1);
        state_d = S_SH_RD;
      end
      S_CLRV: begin
        v_we    = 1'b1;
        v_wdata = row_q & ~(WAYS'(1) << WAY_W'(count_q - WCNT_W'(1)));
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          slot_out_d  = 8'(slot_q);
          way_d       = 2'(res_way_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_out_q;
  assign way_o       = way_q;

  `BHS_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == S_DONE)
  `BHS_ASSERT(a_way_zero_on_fail, clk_i, rst_ni, out_valid_o && status_o != ST_DONE |-> way_o == 2'd0)
  `BHS_ASSERT(a_hash_done_in_hash, clk_i, rst_ni, hash_done |-> state_q == S_HASH)
  `BHS_ASSERT(a_cmp_in_range, clk_i, rst_ni, state_q == S_CMP |-> w_q < count_q)

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// bucketed_hash_set testbench
// drives insert, remove and lookup keys with random gaps and stalls, predicts
// every result with a behavioral copy of the bucket store and checks it
// ----------------------------------------------------------------------------
module tb;
  import bhs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 256;
  localparam int WAYS = 4;
  localparam int KEY_BYTES = 8;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] slot;
    logic [1:0] way;
  } bhs_result_t;

  class hash_set_scoreboard;
    logic [63:0] key_mem[SLOTS*WAYS];
    logic [3:0]  len_mem[SLOTS*WAYS];
    bit          occupied[SLOTS*WAYS];
    int unsigned slot_count;
    int unsigned way_count;
    bhs_result_t pending[$];
    int          errors;

    function new();
      foreach (occupied[i]) occupied[i] = 0;
      slot_count = 256;
      way_count = 4;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [8:0] data);
      if (idx == CFG_SLOTS) slot_count = data;
      else if (idx == CFG_WAYS) way_count = data[2:0];
    endfunction

    function void note_request(logic [1:0] mode, logic [63:0] key, logic [3:0] klen);
      int unsigned len, nslots, nways, slot, base, count, w, j, hit_way;
      logic [31:0] h;
      logic [63:0] k;
      bit hit;
      bhs_result_t r;
      len = (klen > KEY_BYTES) ? KEY_BYTES : klen;
      k = (len >= 8) ? key : key & ((64'd1 << (8 * len)) - 64'd1);
      h = HASH_SEED;
      for (int i = 0; i < len; i++) h = (h << HASH_SHIFT) + h + k[8*i +: 8];
      nslots = (slot_count == 0) ? 1 : (slot_count > SLOTS) ? SLOTS : slot_count;
      nways = (way_count == 0) ? 1 : (way_count > WAYS) ? WAYS : way_count;
      slot = h % nslots;
      base = slot * WAYS;
      count = 0;
      while (count < nways && occupied[base + count]) count++;
      r = '{status: ST_MISS, slot: slot[7:0], way: 2'd0};
      if (mode == MODE_INSERT) begin
        if (count < nways) begin
          key_mem[base + count] = k;
          len_mem[base + count] = 4'(len);
          occupied[base + count] = 1;
          r.status = ST_DONE;
          r.way = 2'(count);
        end else begin
          r.status = ST_FULL;
        end
      end else begin
        hit = 0;
        hit_way = 0;
        for (w = 0; w < count; w++)
          if (!hit && len_mem[base + w] == len && key_mem[base + w] == k) begin
            hit = 1;
            hit_way = w;
          end
        if (hit) begin
          r.status = ST_DONE;
          r.way = 2'(hit_way);
          if (mode == MODE_REMOVE) begin
            for (j = hit_way + 1; j < count; j++) begin
              key_mem[base + j - 1] = key_mem[base + j];
              len_mem[base + j - 1] = len_mem[base + j];
            end
            occupied[base + count - 1] = 0;
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(bhs_result_t got);
      bhs_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.slot !== exp.slot) begin
        $display("%0t: slot exp %0d got %0d", $time, exp.slot, got.slot);
        errors++;
      end
      if (got.way !== exp.way) begin
        $display("%0t: way exp %0d got %0d", $time, exp.way, got.way);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  mode_i = '0;
  logic [63:0] key_i = '0;
  logic [3:0]  key_len_i = 4'd1;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [1:0]  status_o;
  logic [7:0]  slot_o;
  logic [1:0]  way_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [8:0]  cfg_data_i = '0;

  hash_set_scoreboard sb = new();
  bit stall_enable;
  logic [63:0] key_pool[16];
  logic [3:0]  len_pool[16];

  bucketed_hash_set #(.SLOTS(SLOTS), .WAYS(WAYS), .KEY_BYTES(KEY_BYTES)) DUT (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // receiver side: sample at rising edge, change stall at falling edge
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{status: status_o, slot: slot_o, way: way_o});

  always @(negedge clk_i) begin
    if (!stall_enable) out_stall_i <= 0;
    else if ($urandom_range(0, 99) < 8) out_stall_i <= 1;
    else if (out_stall_i && $urandom_range(0, 99) < 70) out_stall_i <= 1;
    else out_stall_i <= 0;
  end

  task automatic send_item(logic [1:0] mode, logic [63:0] key, logic [3:0] klen);
    int g;
    g = gap_len();
    // the previous beat drops valid at the current falling edge
    repeat (g + 1) @(negedge clk_i);
    mode_i <= mode;
    key_i <= key;
    key_len_i <= klen;
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(mode, key, klen);
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
    // the block may still be finishing its last item
    repeat (100) @(negedge clk_i);
  endtask

  task automatic random_phase(int n);
    int sel;
    logic [1:0] mode;
    logic [63:0] key;
    logic [3:0] klen;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 15);
      if ($urandom_range(0, 99) < 80) begin
        // reuse a pooled key so removes and lookups hit
        key = key_pool[sel] ^ ({$urandom, $urandom} & ~((64'd1 << (8 * len_pool[sel])) - 1));
        klen = len_pool[sel];
        if (len_pool[sel] >= 8) key = key_pool[sel];
      end else begin
        key = {$urandom, $urandom};
        klen = 4'($urandom_range(0, 15));
      end
      mode = $urandom_range(0, 99) < 40 ? MODE_INSERT :
             $urandom_range(0, 99) < 55 ? MODE_REMOVE : 2'($urandom_range(2, 3));
      send_item(mode, key, klen);
      if (i == n / 2 && n > 100) drain();
    end
  endtask

  initial begin
    stall_enable = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // directed: extremes, modes, empty and overlong keys, full bucket
    send_item(MODE_LOOKUP, 64'h0, 4'd0);
    send_item(MODE_INSERT, 64'h0, 4'd0);
    send_item(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 4'd0);
    send_item(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_item(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    send_item(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9);
    send_item(MODE_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_item(MODE_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_item(MODE_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_item(MODE_INSERT, 64'hABCD_EF01_2345_6741, 4'd1);
    send_item(MODE_LOOKUP, 64'h0000_0000_0000_0041, 4'd1);
    drain();
    write_reg(CFG_SLOTS, 9'd1);
    write_reg(CFG_WAYS, 9'd4);
    for (int i = 0; i < 6; i++) send_item(MODE_INSERT, 64'h10 + i, 4'd2);
    send_item(MODE_REMOVE, 64'h11, 4'd2);
    send_item(MODE_LOOKUP, 64'h13, 4'd2);
    send_item(MODE_REMOVE, 64'h77, 4'd2);
    drain();
    stall_enable = 1;
    // configurations: reset values, extremes, out of range
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(CFG_SLOTS, 9'd256); write_reg(CFG_WAYS, 9'd4); end
        1: begin write_reg(CFG_SLOTS, 9'd0);   write_reg(CFG_WAYS, 9'd0); end
        2: begin write_reg(CFG_SLOTS, 9'd511); write_reg(CFG_WAYS, 9'd7); end
        3: begin write_reg(CFG_SLOTS, 9'd2);   write_reg(CFG_WAYS, 9'd1); end
        default: begin
          write_reg(CFG_SLOTS, 9'($urandom_range(1, 300)));
          write_reg(CFG_WAYS, 9'($urandom_range(0, 7)));
        end
      endcase
      foreach (key_pool[i]) begin
        len_pool[i] = 4'($urandom_range(0, 8));
        key_pool[i] = {$urandom, $urandom};
      end
      random_phase(ph == 0 ? 500 : 170);
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("bucketed_hash_set verification clean");
    else
      $display("bucketed_hash_set verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("bucketed_hash_set verification failed");
    $finish;
  end
endmodule
